[rtl/cvt_pkg.sv]
// ----------------------------------------------------------------------------
// cvt_pkg
// types, register indexes and degree sine table for the view transform
// ----------------------------------------------------------------------------
package cvt_pkg;

  localparam int unsigned AngleWidth = 9;
  localparam int unsigned TrigWidth  = 16;   // signed q1.14
  localparam int unsigned TrigFrac   = 14;
  localparam int unsigned CoordW     = 16;
  localparam int unsigned IdxWidth   = 3;

  typedef enum logic [IdxWidth-1:0] {
    REG_YAW    = 3'd0,
    REG_PITCH  = 3'd1,
    REG_ROLL   = 3'd2,
    REG_DIST   = 3'd3,
    REG_CX     = 3'd4,
    REG_CY     = 3'd5,
    REG_CZ     = 3'd6,
    REG_UNUSED = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic signed [CoordW-1:0] point_z;
    logic signed [CoordW-1:0] point_y;
    logic signed [CoordW-1:0] point_x;
  } point_t;

  typedef struct packed {
    logic signed [CoordW-1:0] view_z;
    logic signed [CoordW-1:0] view_y;
    logic signed [CoordW-1:0] view_x;
  } view_t;

  typedef logic signed [TrigWidth-1:0] trig_t;

  // sin(k deg), k = 0..90, q1.14
  function automatic logic [TrigWidth-1:0] quarter_sin(input logic [6:0] k);
    logic [TrigWidth-1:0] r;
    unique case (k)
      7'd0: r = 16'd0;      7'd1: r = 16'd286;    7'd2: r = 16'd572;
      7'd3: r = 16'd857;    7'd4: r = 16'd1143;   7'd5: r = 16'd1428;
      7'd6: r = 16'd1713;   7'd7: r = 16'd1997;   7'd8: r = 16'd2280;
      7'd9: r = 16'd2563;   7'd10: r = 16'd2845;  7'd11: r = 16'd3126;
      7'd12: r = 16'd3406;  7'd13: r = 16'd3686;  7'd14: r = 16'd3964;
      7'd15: r = 16'd4240;  7'd16: r = 16'd4516;  7'd17: r = 16'd4790;
      7'd18: r = 16'd5063;  7'd19: r = 16'd5334;  7'd20: r = 16'd5604;
      7'd21: r = 16'd5872;  7'd22: r = 16'd6138;  7'd23: r = 16'd6402;
      7'd24: r = 16'd6664;  7'd25: r = 16'd6924;  7'd26: r = 16'd7182;
      7'd27: r = 16'd7438;  7'd28: r = 16'd7692;  7'd29: r = 16'd7943;
      7'd30: r = 16'd8192;  7'd31: r = 16'd8438;  7'd32: r = 16'd8682;
      7'd33: r = 16'd8923;  7'd34: r = 16'd9162;  7'd35: r = 16'd9397;
      7'd36: r = 16'd9630;  7'd37: r = 16'd9860;  7'd38: r = 16'd10087;
      7'd39: r = 16'd10311; 7'd40: r = 16'd10531; 7'd41: r = 16'd10749;
      7'd42: r = 16'd10963; 7'd43: r = 16'd11174; 7'd44: r = 16'd11381;
      7'd45: r = 16'd11585; 7'd46: r = 16'd11786; 7'd47: r = 16'd11982;
      7'd48: r = 16'd12176; 7'd49: r = 16'd12365; 7'd50: r = 16'd12551;
      7'd51: r = 16'd12733; 7'd52: r = 16'd12911; 7'd53: r = 16'd13085;
      7'd54: r = 16'd13255; 7'd55: r = 16'd13421; 7'd56: r = 16'd13583;
      7'd57: r = 16'd13741; 7'd58: r = 16'd13894; 7'd59: r = 16'd14044;
      7'd60: r = 16'd14189; 7'd61: r = 16'd14330; 7'd62: r = 16'd14466;
      7'd63: r = 16'd14598; 7'd64: r = 16'd14726; 7'd65: r = 16'd14849;
      7'd66: r = 16'd14968; 7'd67: r = 16'd15082; 7'd68: r = 16'd15191;
      7'd69: r = 16'd15296; 7'd70: r = 16'd15396; 7'd71: r = 16'd15491;
      7'd72: r = 16'd15582; 7'd73: r = 16'd15668; 7'd74: r = 16'd15749;
      7'd75: r = 16'd15826; 7'd76: r = 16'd15897; 7'd77: r = 16'd15964;
      7'd78: r = 16'd16026; 7'd79: r = 16'd16083; 7'd80: r = 16'd16135;
      7'd81: r = 16'd16182; 7'd82: r = 16'd16225; 7'd83: r = 16'd16262;
      7'd84: r = 16'd16294; 7'd85: r = 16'd16322; 7'd86: r = 16'd16344;
      7'd87: r = 16'd16362; 7'd88: r = 16'd16374; 7'd89: r = 16'd16382;
      default: r = 16'd16384;
    endcase
    return r;
  endfunction

  // sine of a whole-degree angle below 360
  function automatic trig_t sin_deg(input logic [AngleWidth-1:0] a);
    logic [TrigWidth-1:0] m;
    logic [AngleWidth-1:0] r;
    trig_t s;
    if (a < 9'd90) begin
      m = quarter_sin(a[6:0]);
      s = m;
    end else if (a < 9'd180) begin
      r = 9'd180 - a;
      m = quarter_sin(r[6:0]);
      s = m;
    end else if (a < 9'd270) begin
      r = a - 9'd180;
      m = quarter_sin(r[6:0]);
      s = -$signed(m);
    end else begin
      r = 9'd360 - a;
      m = quarter_sin(r[6:0]);
      s = -$signed(m);
    end
    return s;
  endfunction

  function automatic logic [AngleWidth-1:0] mod360(input logic [AngleWidth-1:0] a);
    return (a >= 9'd360) ? a - 9'd360 : a;
  endfunction

  // clamp a q.28 product sum, rounded to q1.14, into [-1, 1]
  function automatic trig_t round_clamp(input logic signed [34:0] s);
    logic signed [34:0] r;
    r = (s + 35'sd8192) >>> TrigFrac;
    if (r > 35'sd16384) return 16'sd16384;
    if (r < -35'sd16384) return -16'sd16384;
    return r[TrigWidth-1:0];
  endfunction

endpackage

[rtl/camera_view_transform_3d.sv]
// ----------------------------------------------------------------------------
// camera_view_transform_3d
// orbit camera view transform: view = R * (p - camera position), saturated
// ----------------------------------------------------------------------------
// results are registered through the difference, product and sum stages; one point per cycle while busy is low
// busy stays high after a register write while the matrix derives
// reset: registers zero, identity matrix, camera at origin; results not stallable
module camera_view_transform_3d import cvt_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  point_t                 point_i,
  output logic                   done,
  output view_t                  view_o,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [IdxWidth-1:0]    cfg_index,
  input  logic [CoordW-1:0]      cfg_data
);

  logic [AngleWidth-1:0] yaw_q, pitch_q, roll_q;
  logic [CoordW-1:0] dist_q;
  logic signed [CoordW-1:0] cx_q, cy_q, cz_q;
  logic [3:0] hold_q;
  logic cfg_fire;
  trig_t rot [9];
  logic signed [CoordW-1:0] pos [3];

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid & cfg_ready;
  assign busy      = |hold_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      {yaw_q, pitch_q, roll_q} <= '0;
      {dist_q, cx_q, cy_q, cz_q} <= '0;
      hold_q <= '0;
    end else begin
      hold_q <= {hold_q[2:0], cfg_fire};
      if (cfg_fire) begin
        unique case (reg_idx_e'(cfg_index))
          REG_YAW:   yaw_q   <= cfg_data[AngleWidth-1:0];
          REG_PITCH: pitch_q <= cfg_data[AngleWidth-1:0];
          REG_ROLL:  roll_q  <= cfg_data[AngleWidth-1:0];
          REG_DIST:  dist_q  <= cfg_data[CoordW-1:0];
          REG_CX:    cx_q    <= cfg_data[CoordW-1:0];
          REG_CY:    cy_q    <= cfg_data[CoordW-1:0];
          REG_CZ:    cz_q    <= cfg_data[CoordW-1:0];
          default: ;
        endcase
      end
    end
  end

  cvt_setup u_setup (
    .clk_i, .rst_ni, .go_i(hold_q[0]),
    .yaw_i(yaw_q), .pitch_i(pitch_q), .roll_i(roll_q), .dist_i(dist_q),
    .cx_i(cx_q), .cy_i(cy_q), .cz_i(cz_q), .rot_o(rot), .pos_o(pos)
  );

  // stage 1: differences, stage 2: products, stage 3: sums and saturation
  logic [2:0] vld_q;
  logic signed [CoordW:0] d_q [3];
  logic signed [CoordW+16:0] p_q [9];
  view_t out_q;
  logic signed [CoordW:0] d_d [3];
  logic signed [CoordW+18:0] s;
  logic signed [CoordW-1:0] vs [3];

  assign d_d[0] = point_i.point_x - pos[0];
  assign d_d[1] = point_i.point_y - pos[1];
  assign d_d[2] = point_i.point_z - pos[2];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s = p_q[3*i] + p_q[3*i+1] + p_q[3*i+2] + 8192;
      s = s >>> TrigFrac;
      if (s > 32767) vs[i] = 16'sh7fff;
      else if (s < -32768) vs[i] = 16'sh8000;
      else vs[i] = s[CoordW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else vld_q <= {vld_q[1:0], start & ~busy};
  end

  always_ff @(posedge clk_i) begin
    d_q <= d_d;
    for (int i = 0; i < 9; i++) p_q[i] <= rot[i] * d_q[i%3];
    out_q.view_x <= vs[0];
    out_q.view_y <= vs[1];
    out_q.view_z <= vs[2];
  end

  assign done   = vld_q[2];
  assign view_o = out_q;

  a_cfg_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_fire |=> busy) else $error("busy not raised after write");
  a_done_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##3 done) else $error("result lost");

endmodule

[rtl/cvt_setup.sv]
// ----------------------------------------------------------------------------
// cvt_setup
// derives camera position and rotation matrix from configuration, multi-cycle
// ----------------------------------------------------------------------------
module cvt_setup import cvt_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     go_i,
  input  logic [AngleWidth-1:0]    yaw_i,
  input  logic [AngleWidth-1:0]    pitch_i,
  input  logic [AngleWidth-1:0]    roll_i,
  input  logic [CoordW-1:0]        dist_i,
  input  logic signed [CoordW-1:0] cx_i,
  input  logic signed [CoordW-1:0] cy_i,
  input  logic signed [CoordW-1:0] cz_i,
  output trig_t                    rot_o [9],
  output logic signed [CoordW-1:0] pos_o [3]
);

  // step 1: trig, step 2: pitch*yaw and rel terms, step 3: roll and position
  logic [1:0] step_q;
  trig_t sy_q, cyw_q, sp_q, cp_q, sr_q, cr_q;
  trig_t rel_q [3];
  trig_t t_q [9];
  trig_t rot_q [9];
  logic signed [CoordW-1:0] pos_q [3];
  trig_t tmp [9];
  trig_t rot_d [9];
  trig_t rel_d [3];
  logic signed [CoordW-1:0] pos_d [3];
  logic signed [CoordW-1:0] ctr [3];

  assign ctr[0] = cx_i;
  assign ctr[1] = cy_i;
  assign ctr[2] = cz_i;

  always_comb begin
    logic signed [34:0] p;
    logic signed [CoordW+17:0] dp;
    logic signed [CoordW+2:0] sum;
    rel_d[0] = round_clamp(35'(cp_q * sy_q));
    rel_d[1] = sp_q;
    rel_d[2] = round_clamp(35'(cp_q * cyw_q));
    for (int i = 0; i < 3; i++) begin
      dp = $signed({2'b0, dist_i}) * rel_q[i];
      sum = (CoordW+3)'((dp + 8192) >>> TrigFrac) + ctr[i];
      if (sum > (CoordW+3)'(32767)) pos_d[i] = 16'sh7fff;
      else if (sum < -(CoordW+3)'(32768)) pos_d[i] = 16'sh8000;
      else pos_d[i] = sum[CoordW-1:0];
    end
    // pitch * yaw
    tmp[0] = cyw_q;
    tmp[1] = '0;
    tmp[2] = -sy_q;
    tmp[3] = round_clamp(35'(-(sp_q * sy_q)));
    tmp[4] = cp_q;
    tmp[5] = round_clamp(35'(-(sp_q * cyw_q)));
    tmp[6] = round_clamp(35'(cp_q * sy_q));
    tmp[7] = sp_q;
    tmp[8] = round_clamp(35'(cp_q * cyw_q));
    // roll * t
    for (int j = 0; j < 3; j++) begin
      p = 35'(cr_q * t_q[j]) - 35'(sr_q * t_q[3+j]);
      rot_d[j] = round_clamp(p);
      p = 35'(sr_q * t_q[j]) + 35'(cr_q * t_q[3+j]);
      rot_d[3+j] = round_clamp(p);
      rot_d[6+j] = round_clamp(35'(t_q[6+j]) <<< TrigFrac);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= 2'd0;
      sy_q   <= '0;
      cyw_q  <= '0;
      sp_q   <= '0;
      cp_q   <= '0;
      sr_q   <= '0;
      cr_q   <= '0;
      for (int i = 0; i < 3; i++) rel_q[i] <= '0;
      for (int i = 0; i < 9; i++) t_q[i] <= '0;
      for (int i = 0; i < 9; i++) rot_q[i] <= (i % 4 == 0) ? 16'sd16384 : 16'sd0;
      for (int i = 0; i < 3; i++) pos_q[i] <= '0;
    end else begin
      step_q <= {step_q[0], go_i};
      if (go_i) begin
        sy_q  <= sin_deg(mod360(yaw_i));
        cyw_q <= sin_deg(mod360(mod360(yaw_i) + 9'd90));
        sp_q  <= sin_deg(mod360(pitch_i));
        cp_q  <= sin_deg(mod360(mod360(pitch_i) + 9'd90));
        sr_q  <= sin_deg(mod360(roll_i));
        cr_q  <= sin_deg(mod360(mod360(roll_i) + 9'd90));
      end
      if (step_q[0]) begin
        rel_q <= rel_d;
        t_q   <= tmp;
      end
      if (step_q[1]) begin
        pos_q <= pos_d;
        rot_q <= rot_d;
      end
    end
  end

  assign rot_o = rot_q;
  assign pos_o = pos_q;

endmodule
